// ===== rtl/core/dual_mode_pid_speed_loop_assert.svh =====
// assertion helpers included by the speed loop top module
`ifndef DUAL_MODE_PID_SPEED_LOOP_ASSERT_SVH
`define DUAL_MODE_PID_SPEED_LOOP_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define DMPID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define DMPID_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dmpid_pkg.sv =====
package dmpid_pkg;

  localparam int FRAC_BITS = 8;
  localparam int ACC_W     = 48;
  localparam int ERR_W     = 17;
  localparam int D1_W      = ERR_W + 1;
  localparam int D2_W      = ERR_W + 3;
  localparam int GAIN_W    = 24;
  localparam int DUTY_W    = 16;
  localparam int PROD_W    = GAIN_W + 1 + D2_W;
  localparam int SUM_W     = ACC_W + 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_GAIN_P   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_DUTY_CAP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              incremental_mode;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [DUTY_W-1:0] duty_cap;
  } cfg_t;

  typedef struct packed {
    err_t e1;
    err_t e2;
    acc_t integral;
    acc_t out_acc;
  } state_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              clamped;
  } res_t;

  // saturate a wide sum to the accumulator range
  function automatic acc_t sat_acc(input logic signed [SUM_W-1:0] v);
    logic in_range;
    acc_t r;
    in_range = (&v[SUM_W-1:ACC_W-1]) || !(|v[SUM_W-1:ACC_W-1]);
    if (in_range) r = v[ACC_W-1:0];
    else if (v[SUM_W-1]) r = {1'b1, {(ACC_W-1){1'b0}}};
    else r = {1'b0, {(ACC_W-1){1'b1}}};
    return r;
  endfunction

endpackage

// ===== rtl/core/dual_mode_pid_speed_loop.sv =====
// Speed-loop PID controller with an incremental and a positional form, chosen by the
// incremental_mode register. Each input transaction carries one control period's target
// speed and measured encoder count and yields exactly one output transaction with the
// clamped duty (integer part of the Q.8 controller output) and a flag set when the output
// was limited to 0 or the duty cap. A transaction is registered, then evaluated
// combinationally by three 25x20 multipliers and a saturating add tree that feed the stored
// errors and accumulators back, so one transaction is taken every clock unless the output
// stalls, and out_tvalid comes through the input and output registers. The gains are
// unsigned Q16.8; the integral (positional form only) and the output accumulator saturate
// at the 48 bit signed range, and the stored output is always the clamped one, so switching
// form keeps the state. The user must write configuration only while the pipeline is empty;
// the block does not enforce it. cfg_ready is always high and unknown indexes are ignored.
module dual_mode_pid_speed_loop (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream, tdata: target_speed [14:0], measured_speed [30:15], zero [31]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,
  // output stream, tdata: duty [15:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dmpid_pkg::DUTY_W-1:0]       out_tdata,
  // output stream, tuser: clamped [0]
  output logic                               out_tuser,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dmpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmpid_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import dmpid_pkg::*;

  `include "dual_mode_pid_speed_loop_assert.svh"

  cfg_t               cfg_r, cfg_nxt;
  state_t             state_r, state_nxt;
  res_t               res_nxt;
  res_t               out_res_r;
  logic               out_valid_r;
  logic               s0_valid_r;
  logic [14:0]        s0_target_r;
  logic signed [15:0] s0_measured_r;
  logic               advance;
  logic               fire;

  // the output register frees up when empty or taken in this cycle
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s0_valid_r && advance;
  assign in_tready = !s0_valid_r || advance;
  assign cfg_ready = 1'b1;

  // register file write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:     cfg_nxt.incremental_mode = cfg_data[0];
        REG_GAIN_P:   cfg_nxt.gain_p           = cfg_data[GAIN_W-1:0];
        REG_GAIN_I:   cfg_nxt.gain_i           = cfg_data[GAIN_W-1:0];
        REG_GAIN_D:   cfg_nxt.gain_d           = cfg_data[GAIN_W-1:0];
        REG_DUTY_CAP: cfg_nxt.duty_cap         = cfg_data[DUTY_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.incremental_mode <= 1'b1;
      cfg_r.gain_p           <= '0;
      cfg_r.gain_i           <= '0;
      cfg_r.gain_d           <= '0;
      cfg_r.duty_cap         <= DUTY_W'(1000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_target_r   <= in_tdata[14:0];
      s0_measured_r <= $signed(in_tdata[30:15]);
    end
  end

  // control law and clamp
  dmpid_calc u_calc (
    .cfg            (cfg_r),
    .state          (state_r),
    .target_speed   (s0_target_r),
    .measured_speed (s0_measured_r),
    .state_nxt      (state_nxt),
    .res            (res_nxt)
  );

  // loop state moves only when a transaction is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.duty;
  assign out_tuser  = out_res_r.clamped;

  // reported duty is the integer part of the stored output
  `DMPID_ASSERT_NEXT(a_duty_matches_acc, fire,
    out_tvalid && out_tdata == state_r.out_acc[FRAC_BITS+DUTY_W-1:FRAC_BITS],
    "duty does not match the stored output")
  // stored output is never negative
  `DMPID_ASSERT(a_acc_not_negative, !state_r.out_acc[ACC_W-1],
    "output accumulator went negative")
  // integral holds in incremental form
  `DMPID_ASSERT_NEXT(a_integral_holds, fire && cfg_r.incremental_mode,
    $stable(state_r.integral), "integral moved in incremental form")
  // error history shifts by one per transaction
  `DMPID_ASSERT_NEXT(a_error_shift, fire, state_r.e2 == $past(state_r.e1),
    "error history did not shift")

endmodule

// ===== rtl/core/dmpid_calc.sv =====
module dmpid_calc (
  input  dmpid_pkg::cfg_t          cfg,
  input  dmpid_pkg::state_t        state,
  input  logic [14:0]              target_speed,
  input  logic signed [15:0]       measured_speed,
  output dmpid_pkg::state_t        state_nxt,
  output dmpid_pkg::res_t          res
);
  import dmpid_pkg::*;

  err_t                     e0;
  logic signed [D1_W-1:0]   diff1;
  logic signed [D2_W-1:0]   diff2;
  logic signed [D2_W-1:0]   e0_x;
  logic signed [D2_W-1:0]   op_p;
  logic signed [D2_W-1:0]   op_d;
  logic signed [GAIN_W:0]   gp, gi, gd;
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
  logic signed [SUM_W-1:0]  sum_inc, sum_int, sum_pos;
  acc_t                     int_nxt;
  acc_t                     y_sat;
  acc_t                     y;
  acc_t                     limit;
  logic                     clamped;

  // error fits 17 bits signed for all input patterns
  assign e0    = $signed({2'b00, target_speed}) - $signed({measured_speed[15], measured_speed});
  assign diff1 = $signed({e0[ERR_W-1], e0}) - $signed({state.e1[ERR_W-1], state.e1});
  assign diff2 = D2_W'(e0) - (D2_W'($signed(state.e1)) <<< 1) + D2_W'($signed(state.e2));
  assign e0_x  = D2_W'(e0);

  // operands steered by mode so three multipliers serve both forms
  assign op_p = cfg.incremental_mode ? D2_W'(diff1) : e0_x;
  assign op_d = cfg.incremental_mode ? diff2 : D2_W'(diff1);

  assign gp = $signed({1'b0, cfg.gain_p});
  assign gi = $signed({1'b0, cfg.gain_i});
  assign gd = $signed({1'b0, cfg.gain_d});

  assign prod_p = gp * op_p;
  assign prod_i = gi * e0_x;
  assign prod_d = gd * op_d;

  assign sum_inc = SUM_W'($signed(state.out_acc)) + SUM_W'(prod_p) + SUM_W'(prod_i)
                 + SUM_W'(prod_d);
  assign sum_int = SUM_W'($signed(state.integral)) + SUM_W'(prod_i);
  assign int_nxt = sat_acc(sum_int);
  assign sum_pos = SUM_W'(int_nxt) + SUM_W'(prod_p) + SUM_W'(prod_d);

  assign y_sat = cfg.incremental_mode ? sat_acc(sum_inc) : sat_acc(sum_pos);
  assign limit = acc_t'({cfg.duty_cap, {FRAC_BITS{1'b0}}});

  always_comb begin
    y       = y_sat;
    clamped = 1'b0;
    if (y_sat > limit) begin
      y       = limit;
      clamped = 1'b1;
    end else if (y_sat < 0) begin
      y       = '0;
      clamped = 1'b1;
    end
  end

  always_comb begin
    state_nxt.e1       = e0;
    state_nxt.e2       = state.e1;
    state_nxt.integral = cfg.incremental_mode ? state.integral : int_nxt;
    state_nxt.out_acc  = y;
    res.duty           = y[FRAC_BITS+DUTY_W-1:FRAC_BITS];
    res.clamped        = clamped;
  end

endmodule

// ===== dv/dual_mode_pid_speed_loop_check.sv =====
// watches the three channels, predicts duty and clamp per control period
module dmpid_duty_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [31:0]                     in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [dmpid_pkg::DUTY_W-1:0]    out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dmpid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmpid_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import dmpid_pkg::*;

  cfg_t regs;
  err_t err_last;
  err_t err_prev;
  acc_t integ;
  acc_t out_acc;
  res_t duty_due[$];
  int   bad_count = 0;
  int   due_count = 0;

  assign mismatches  = bad_count;
  assign outstanding = due_count;

  function automatic longint clip_acc(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ACC_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one control period: updates errors and accumulators, returns the duty transaction
  function automatic res_t next_duty(input logic [14:0] tgt, input logic signed [15:0] meas);
    longint e0, e1, e2, kp, ki, kd, y, lim;
    res_t   r;
    e0 = longint'(tgt) - longint'(meas);
    e1 = longint'(err_last);
    e2 = longint'(err_prev);
    kp = longint'(regs.gain_p);
    ki = longint'(regs.gain_i);
    kd = longint'(regs.gain_d);
    if (regs.incremental_mode) begin
      y = clip_acc(longint'(out_acc) + kp * (e0 - e1) + ki * e0 + kd * (e0 - 2 * e1 + e2));
    end else begin
      integ = acc_t'(clip_acc(longint'(integ) + ki * e0));
      y = clip_acc(longint'(integ) + kp * e0 + kd * (e0 - e1));
    end
    lim = longint'(regs.duty_cap) << FRAC_BITS;
    r.clamped = 1'b0;
    if (y > lim) begin
      y = lim;
      r.clamped = 1'b1;
    end
    if (y < 0) begin
      y = 0;
      r.clamped = 1'b1;
    end
    out_acc  = acc_t'(y);
    err_prev = err_last;
    err_last = err_t'(e0);
    r.duty   = DUTY_W'(y >>> FRAC_BITS);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      regs.incremental_mode = 1'b1;
      regs.gain_p   = '0;
      regs.gain_i   = '0;
      regs.gain_d   = '0;
      regs.duty_cap = DUTY_W'(1000);
      err_last = '0;
      err_prev = '0;
      integ    = '0;
      out_acc  = '0;
      duty_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE:     regs.incremental_mode = cfg_data[0];
          REG_GAIN_P:   regs.gain_p = cfg_data;
          REG_GAIN_I:   regs.gain_i = cfg_data;
          REG_GAIN_D:   regs.gain_d = cfg_data;
          REG_DUTY_CAP: regs.duty_cap = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) duty_due.push_back(next_duty(in_tdata[14:0], in_tdata[30:15]));
      if (out_tvalid && out_tready) begin
        if (duty_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected duty transaction: duty=%0d clamped=%0b", out_tdata, out_tuser);
        end else begin
          want = duty_due.pop_front();
          if (want.duty !== out_tdata || want.clamped !== out_tuser) begin
            bad_count++;
            if (bad_count <= 10)
              $display("duty mismatch: expected duty=%0d clamped=%0b, got duty=%0d clamped=%0b",
                       want.duty, want.clamped, out_tdata, out_tuser);
          end
        end
      end
    end
    due_count = duty_due.size();
  end

endmodule

// ===== dv/dual_mode_pid_speed_loop_test.sv =====
// stimulus and verdict for the speed loop; prediction lives in the checker
module dual_mode_pid_speed_loop_test;
  import dmpid_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TOTAL  = 1650;
  // index with no register behind it, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DUTY_W-1:0]    out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  // idling switches for sender and receiver, and the long receiver hold-off request
  bit tx_gaps  = 1'b1;
  bit rx_gaps  = 1'b1;
  bit hold_req = 1'b0;

  int sent   = 0;
  int cycles = 0;
  int mismatches;
  int outstanding;

  always #4 clk = ~clk;

  dual_mode_pid_speed_loop u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dmpid_duty_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random back-pressure, or a long hold-off while the sender keeps offering
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= rx_gaps ? ($urandom_range(0, 99) >= 13) : 1'b1;
      @(negedge clk);
    end
  end

  // offer one control period; valid stays up into the next call so back-to-back
  // transactions leave no gap on the input channel
  task automatic send_speed(input logic [14:0] tgt, input logic [15:0] meas);
    @(negedge clk);
    while (tx_gaps && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, meas, tgt};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait until every predicted duty transaction has come out
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // mostly small gains so the duty stays inside the clamp, with zero, full scale
  // and wild values mixed in
  function automatic logic [CFG_DAT_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_duty_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'h00FFFF;
      2:       return 24'($urandom_range(0, 65535));
      default: return 24'($urandom_range(100, 5000));
    endcase
  endfunction

  task automatic rand_speed(output logic [14:0] tgt, output logic [15:0] meas);
    int t;
    int m;
    case ($urandom_range(0, 9))
      0: begin
        // corners of both fields
        tgt = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
        case ($urandom_range(0, 2))
          0:       meas = 16'h8000;
          1:       meas = 16'h7FFF;
          default: meas = 16'h0000;
        endcase
      end
      1, 2: begin
        tgt  = 15'($urandom);
        meas = 16'($urandom);
      end
      default: begin
        // settled loop: measured speed close to the target
        t = $urandom_range(0, 32767);
        m = t + int'($urandom_range(0, 4000)) - 2000;
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        tgt  = 15'(t);
        meas = 16'(m);
      end
    endcase
  endtask

  initial begin
    logic [14:0] tgt;
    logic [15:0] meas;
    int          phase;
    int          n;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register reset values: incremental, zero gains, duty limit of 1000
    send_speed(15'd100, 16'd0);
    send_speed(15'h7FFF, 16'h8000);
    send_speed(15'd0, 16'h7FFF);
    send_speed(15'd500, 16'd500);
    drain;

    // incremental form with modest gains, including the odd index that must do nothing
    write_reg(REG_MODE, 24'd1);
    write_reg(REG_GAIN_P, 24'h000100);
    write_reg(REG_GAIN_I, 24'h000040);
    write_reg(REG_GAIN_D, 24'h000020);
    write_reg(REG_DUTY_CAP, 24'd1000);
    write_reg(REG_SPARE, 24'hFFFFFF);
    send_speed(15'd1000, 16'd0);
    send_speed(15'd1000, 16'd990);
    send_speed(15'd1000, 16'd1010);
    send_speed(15'd0, 16'd0);
    send_speed(15'h7FFF, 16'h8000);   // largest error, clamps high
    send_speed(15'd0, 16'h7FFF);      // most negative error, clamps low
    send_speed(15'd2000, 16'd1990);
    send_speed(15'd2000, 16'd2000);
    drain;

    // switch to positional form with state carried over, widest duty, full d gain
    write_reg(REG_MODE, 24'd0);
    write_reg(REG_DUTY_CAP, 24'h00FFFF);
    write_reg(REG_GAIN_D, 24'hFFFFFF);
    send_speed(15'd300, 16'd200);
    send_speed(15'd300, 16'd300);
    send_speed(15'd300, 16'd310);
    send_speed(15'h7FFF, 16'h8000);
    send_speed(15'd0, 16'h7FFF);
    send_speed(15'd0, 16'd0);
    drain;

    // zero duty limit: every non-zero output counts as clamped
    write_reg(REG_DUTY_CAP, 24'd0);
    send_speed(15'd1000, 16'd0);
    send_speed(15'd0, 16'd0);
    drain;

    // back to incremental with full p gain and a huge delta each way
    write_reg(REG_MODE, 24'd1);
    write_reg(REG_GAIN_P, 24'hFFFFFF);
    write_reg(REG_DUTY_CAP, 24'd40000);
    send_speed(15'h7FFF, 16'h8000);
    send_speed(15'd0, 16'h7FFF);
    drain;

    // integral wind-up to the top of the accumulator range, where the output sum overflows
    // on top of it, then back down; no idling on either side for this stretch
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_reg(REG_MODE, 24'd0);
    write_reg(REG_GAIN_P, 24'h000100);
    write_reg(REG_GAIN_I, 24'hFFFFFF);
    write_reg(REG_GAIN_D, 24'h000000);
    write_reg(REG_DUTY_CAP, 24'h00FFFF);
    for (int k = 0; k < 180; k++)
      send_speed(15'(32767 - $urandom_range(0, 50)), 16'(16'h8000 + $urandom_range(0, 50)));
    for (int k = 0; k < 300; k++)
      send_speed(15'($urandom_range(0, 50)), 16'(16'h7FFF - $urandom_range(0, 50)));
    drain;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // random settings per phase, random periods within each phase
    phase = 0;
    while (sent < ITEM_TOTAL) begin
      write_reg(REG_MODE, 24'($urandom_range(0, 1)));
      write_reg(REG_GAIN_P, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GAIN_D, pick_gain());
      write_reg(REG_DUTY_CAP, pick_duty_limit());
      n = $urandom_range(40, 120);
      for (int k = 0; k < n; k++) begin
        // one long receiver hold-off so the block fills up and stalls its input
        if (phase == 2 && k == 10) hold_req = 1'b1;
        rand_speed(tgt, meas);
        send_speed(tgt, meas);
      end
      drain;
      phase++;
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dmpid_pkg.sv
rtl/core/dmpid_calc.sv
rtl/core/dual_mode_pid_speed_loop.sv
dv/dual_mode_pid_speed_loop_check.sv
dv/dual_mode_pid_speed_loop_test.sv
